// ----- rtl/core/kjss_pkg.sv -----
// ----------------------------------------------------------------------------
// kjss_pkg
// Shared constants and helpers of the flow spread sketch: hash constants,
// register map, estimator constants and the small-range table.
// ----------------------------------------------------------------------------
package kjss_pkg;

	localparam int ROW_COUNT_DEF    = 3;
	localparam int COLUMN_COUNT_DEF = 1024;
	localparam int REGS_PER_CTR     = 16;
	localparam int REG_W            = 5;
	localparam int WORD_W           = REGS_PER_CTR * REG_W;

	localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2  = 32'h1b873593;
	localparam logic [31:0] MM_C3  = 32'h85ebca6b;
	localparam logic [31:0] MM_C4  = 32'hc2b2ae35;
	localparam logic [31:0] MM_ADD = 32'he6546b64;
	localparam logic [31:0] MM_LEN = 32'd4;

	// register map, index = paddr[3:2]
	localparam logic [1:0] REG_ROW0_SEED = 2'd0;
	localparam logic [1:0] REG_ROW1_SEED = 2'd1;
	localparam logic [1:0] REG_ROW2_SEED = 2'd2;
	localparam logic [1:0] REG_ELEM_SEED = 2'd3;

	localparam int SUM_W = 34;
	localparam int NUM_W = 53;
	// alpha(Q16) * m * m * 2^29
	localparam logic [NUM_W-1:0] EST_NUM   = 53'd44106 << 37;
	// 2.5 * m in Q16
	localparam logic [NUM_W-1:0] EST_SMALL = 53'd2621440;

	function automatic logic [5:0] small_range(input logic [4:0] zeros);
		logic [5:0] v;
		case (zeros)
			5'd0:    v = 6'd44;
			5'd1:    v = 6'd44;
			5'd2:    v = 6'd33;
			5'd3:    v = 6'd26;
			5'd4:    v = 6'd22;
			5'd5:    v = 6'd18;
			5'd6:    v = 6'd15;
			5'd7:    v = 6'd13;
			5'd8:    v = 6'd11;
			5'd9:    v = 6'd9;
			5'd10:   v = 6'd7;
			5'd11:   v = 6'd5;
			5'd12:   v = 6'd4;
			5'd13:   v = 6'd3;
			5'd14:   v = 6'd2;
			5'd15:   v = 6'd1;
			default: v = 6'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/core/kjss_hash.sv -----
// ----------------------------------------------------------------------------
// kjss_hash
// Murmur3 of one 32-bit word over five multiply steps on one shared
// multiplier, then the hash reduced modulo the column count by a reciprocal
// multiply and one compare and subtract.
// ----------------------------------------------------------------------------
module kjss_hash #(
	parameter int COLUMN_COUNT = kjss_pkg::COLUMN_COUNT_DEF,
	parameter int CW           = $clog2(COLUMN_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [31:0]   word,
	input  logic [31:0]   seed,
	output logic          done,
	output logic [31:0]   hash,
	output logic [CW-1:0] column
);

	// floor(2^(31+CW) / COLUMN_COUNT) fits 32 bits and leaves the quotient
	// estimate at most one below the true quotient
	localparam int          SH     = 31 + CW;
	localparam logic [31:0] RECIP  = 32'((64'd1 << SH) / 64'(COLUMN_COUNT));
	localparam logic [31:0] COLS32 = 32'(COLUMN_COUNT);

	logic [31:0]   x_q;
	logic [31:0]   seed_q;
	logic [31:0]   quo_q;
	logic [2:0]    cnt_q;
	logic          done_q;
	logic [CW-1:0] rem_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] hx;
	logic [31:0] x_next;
	logic [31:0] diff;

	always_comb begin
		hx = x_q ^ seed_q;
		case (cnt_q)
			3'd1: begin
				mul_a = x_q;
				mul_b = kjss_pkg::MM_C1;
			end
			3'd2: begin
				mul_a = {x_q[16:0], x_q[31:17]};
				mul_b = kjss_pkg::MM_C2;
			end
			3'd3: begin
				mul_a = {hx[18:0], hx[31:19]};
				mul_b = 32'd5;
			end
			3'd4: begin
				mul_a = x_q ^ (x_q >> 16);
				mul_b = kjss_pkg::MM_C3;
			end
			3'd5: begin
				mul_a = x_q ^ (x_q >> 13);
				mul_b = kjss_pkg::MM_C4;
			end
			3'd6: begin
				mul_a = hash;
				mul_b = RECIP;
			end
			3'd7: begin
				mul_a = quo_q;
				mul_b = COLS32;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod   = 64'(mul_a) * 64'(mul_b);
		x_next = (cnt_q == 3'd3) ?
			((prod[31:0] + kjss_pkg::MM_ADD) ^ kjss_pkg::MM_LEN) : prod[31:0];
		diff   = hash - prod[31:0];
	end

	assign hash = x_q ^ (x_q >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			cnt_q  <= 3'd1;
			done_q <= 1'b0;
		end else if (cnt_q == 3'd7) begin
			cnt_q  <= '0;
			done_q <= 1'b1;
		end else if (cnt_q != 3'd0) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= word;
			seed_q <= seed;
		end else if (cnt_q >= 3'd1 && cnt_q <= 3'd5) begin
			x_q <= x_next;
		end else if (cnt_q == 3'd6) begin
			quo_q <= 32'(prod >> SH);
		end else if (cnt_q == 3'd7) begin
			// remainder lies below twice the column count
			if (diff >= COLS32)
				rem_q <= CW'(diff - COLS32);
			else
				rem_q <= CW'(diff);
		end
	end

	assign done   = done_q;
	assign column = rem_q;

endmodule

// ----- rtl/core/kjoin_spread_sketch_unit.sv -----
// ----------------------------------------------------------------------------
// kjoin_spread_sketch_unit
// Flow spread sketch: rows of HyperLogLog counters in on-chip memories,
// updated by read-modify-write and queried with a min-across-rows estimate.
// ----------------------------------------------------------------------------
// channel  | ports                                       | handshake
// cfg      | psel penable pwrite paddr pwdata prdata     | APB, pready high
// item     | opcode flow_key element                     | start && !busy
// result   | spread_estimate                             | done, one cycle
//
// Busy stays high while an update or query runs, so the next transaction is
// taken only after busy falls. The steps are the key and element hashes
// (five multiply steps, a reciprocal multiply and a remainder fix-up), one
// memory read, then either the write-back, or a min step, 16 sum steps, a
// 53-step bit-serial divide and a finish step; after a query done rises as
// busy falls. After reset a clearing pass over all COLUMN_COUNT columns zeros
// the memories with busy high. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module kjoin_spread_sketch_unit #(
	parameter int ROW_COUNT    = kjss_pkg::ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = kjss_pkg::COLUMN_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [31:0] flow_key,
	input  logic [31:0] element,
	output logic        done,
	output logic [31:0] spread_estimate
);

	localparam int CW = $clog2(COLUMN_COUNT);
	localparam int WW = kjss_pkg::WORD_W;
	localparam int RW = kjss_pkg::REG_W;
	localparam int NR = kjss_pkg::REGS_PER_CTR;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLEAR = 4'd1;
	localparam logic [3:0] ST_HASH  = 4'd2;
	localparam logic [3:0] ST_READ  = 4'd3;
	localparam logic [3:0] ST_WRITE = 4'd4;
	localparam logic [3:0] ST_MINS  = 4'd5;
	localparam logic [3:0] ST_SUM   = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0]  state_q;
	logic [31:0] row_seed_q [3];
	logic [31:0] elem_seed_q;
	logic        op_q;
	logic [CW-1:0] clr_q;
	logic [4:0]  rank_q;
	logic [3:0]  sel_q;
	logic [RW-1:0] mins_q [NR];
	logic [RW-1:0] mins [NR];
	logic [kjss_pkg::SUM_W-1:0] sum_q;
	logic [4:0]  zeros_q;
	logic [3:0]  idx_q;
	logic [kjss_pkg::SUM_W:0]   rem_q;
	logic [kjss_pkg::NUM_W-1:0] quo_q;
	logic [5:0]  dcnt_q;
	logic        done_q;
	logic [31:0] result_q;

	logic        accept;
	logic        cfg_wr;
	logic        hash_go;
	logic        elem_done;
	logic [31:0] elem_hash;
	logic [CW-1:0] elem_col;
	logic [CW-1:0] col [ROW_COUNT];
	logic [WW-1:0] rd_q [ROW_COUNT];
	logic [WW-1:0] new_word [ROW_COUNT];
	logic [4:0]  rank_c;
	logic [4:0]  rmin;
	logic [kjss_pkg::SUM_W-1:0] term;
	logic [kjss_pkg::SUM_W:0]   r2;
	logic        clearing;
	logic        writing;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign hash_go  = accept;
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign clearing = (state_q == ST_CLEAR);
	assign writing  = (state_q == ST_WRITE);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_seed_q[0] <= 32'd0;
			row_seed_q[1] <= 32'd1;
			row_seed_q[2] <= 32'd2;
			elem_seed_q   <= 32'd3;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				kjss_pkg::REG_ROW0_SEED: row_seed_q[0] <= pwdata;
				kjss_pkg::REG_ROW1_SEED: row_seed_q[1] <= pwdata;
				kjss_pkg::REG_ROW2_SEED: row_seed_q[2] <= pwdata;
				default:                 elem_seed_q   <= pwdata;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			kjss_pkg::REG_ROW0_SEED: prdata = row_seed_q[0];
			kjss_pkg::REG_ROW1_SEED: prdata = row_seed_q[1];
			kjss_pkg::REG_ROW2_SEED: prdata = row_seed_q[2];
			default:                 prdata = elem_seed_q;
		endcase
	end

	// element hash
	kjss_hash #(.COLUMN_COUNT(COLUMN_COUNT), .CW(CW)) u_elem_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (hash_go),
		.word   (element),
		.seed   (elem_seed_q),
		.done   (elem_done),
		.hash   (elem_hash),
		.column (elem_col)
	);

	// rows: key hash and counter memory
	for (genvar r = 0; r < ROW_COUNT; r++) begin : g_row
		logic [WW-1:0] mem [COLUMN_COUNT];
		logic [31:0]   row_hash;
		logic          row_done;

		kjss_hash #(.COLUMN_COUNT(COLUMN_COUNT), .CW(CW)) u_key_hash (
			.clk    (clk),
			.arst_n (arst_n),
			.go     (hash_go),
			.word   (flow_key),
			.seed   (row_seed_q[r]),
			.done   (row_done),
			.hash   (row_hash),
			.column (col[r])
		);

		always_comb begin
			new_word[r] = rd_q[r];
			for (int j = 0; j < NR; j++) begin
				if (4'(j) == sel_q && rd_q[r][j*RW +: RW] < rank_q)
					new_word[r][j*RW +: RW] = rank_q;
			end
		end

		always_ff @(posedge clk) begin
			if (clearing)
				mem[clr_q] <= '0;
			else if (writing && !op_q)
				mem[col[r]] <= new_word[r];
			rd_q[r] <= mem[col[r]];
		end
	end

	// rank: leading zeros of the low 28 bits plus one
	always_comb begin
		rank_c = 5'd29;
		for (int i = 0; i < 28; i++) begin
			if (elem_hash[i])
				rank_c = 5'(27 - i + 1);
		end
	end

	// per-register minimum across rows
	always_comb begin
		for (int j = 0; j < NR; j++) begin
			mins[j] = 5'd31;
			for (int r = 0; r < ROW_COUNT; r++) begin
				if (rd_q[r][j*RW +: RW] < mins[j])
					mins[j] = rd_q[r][j*RW +: RW];
			end
		end
	end

	assign rmin = (mins_q[idx_q] > 5'd29) ? 5'd29 : mins_q[idx_q];
	assign term = kjss_pkg::SUM_W'(1) << (5'd29 - rmin);
	assign r2   = {rem_q[kjss_pkg::SUM_W-1:0], kjss_pkg::EST_NUM[6'd52 - dcnt_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(COLUMN_COUNT - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept)
						state_q <= ST_HASH;
				end
				ST_HASH: begin
					if (elem_done)
						state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= op_q ? ST_MINS : ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_MINS: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (idx_q == 4'(NR - 1))
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dcnt_q == 6'(kjss_pkg::NUM_W - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			op_q <= opcode;
		if (state_q == ST_READ) begin
			rank_q <= rank_c;
			sel_q  <= elem_hash[31:28];
		end
		if (state_q == ST_MINS) begin
			for (int j = 0; j < NR; j++)
				mins_q[j] <= mins[j];
			sum_q   <= '0;
			zeros_q <= '0;
			idx_q   <= '0;
		end
		if (state_q == ST_SUM) begin
			sum_q <= sum_q + term;
			if (mins_q[idx_q] == 5'd0)
				zeros_q <= zeros_q + 5'd1;
			idx_q  <= idx_q + 4'd1;
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= '0;
		end
		if (state_q == ST_DIV) begin
			// restoring divide, one quotient bit a cycle
			if (r2 >= {1'b0, sum_q}) begin
				rem_q <= r2 - {1'b0, sum_q};
				quo_q <= {quo_q[kjss_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= r2;
				quo_q <= {quo_q[kjss_pkg::NUM_W-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 6'd1;
		end
		if (state_q == ST_FIN) begin
			if (quo_q <= kjss_pkg::EST_SMALL)
				result_q <= {26'd0, kjss_pkg::small_range(zeros_q)};
			else if (quo_q[kjss_pkg::NUM_W-1:48] != '0)
				result_q <= 32'hFFFFFFFF;
			else
				result_q <= quo_q[47:16];
		end
	end

	assign done            = done_q;
	assign spread_estimate = result_q;

endmodule

// ----- bench/kjss_checker.sv -----
// ----------------------------------------------------------------------------
// kjss_checker
// Watches the seed register port, the item channel and the result strobe of
// the flow spread sketch, keeps its own copy of the sketch and seeds, predicts
// each spread estimate and compares it with the one that comes out.
// ----------------------------------------------------------------------------
module kjss_checker #(
	parameter int ROWS = 3,
	parameter int COLS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        start,
	input  logic        busy,
	input  logic        opcode,
	input  logic [31:0] flow_key,
	input  logic [31:0] element,
	input  logic        done,
	input  logic [31:0] spread_estimate,
	output int          fail_count,
	output int          pending,
	output int          estimates_seen
);

	logic [4:0]  sketch [3][COLS*16];
	logic [31:0] key_seed [3];
	logic [31:0] elem_seed;
	logic [31:0] estimate_q [$];

	function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic logic [31:0] mix_word(input logic [31:0] w, input logic [31:0] seed);
		logic [31:0] k;
		logic [31:0] h;
		k = w * 32'hcc9e2d51;
		k = rotl(k, 15) * 32'h1b873593;
		h = seed ^ k;
		h = rotl(h, 13) * 32'd5 + 32'he6546b64;
		h = h ^ 32'd4;
		h = h ^ (h >> 16);
		h = h * 32'h85ebca6b;
		h = h ^ (h >> 13);
		h = h * 32'hc2b2ae35;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function automatic int counter_base(input int row, input logic [31:0] key);
		return int'(mix_word(key, key_seed[row]) % COLS) * 16;
	endfunction

	function automatic logic [31:0] spread_of(input logic [31:0] key);
		logic [4:0]  lowest [16];
		logic [63:0] total;
		logic [63:0] est;
		logic [63:0] ans;
		int zeros;
		int base;
		int r;
		for (int j = 0; j < 16; j++) lowest[j] = 5'd31;
		for (int row = 0; row < ROWS; row++) begin
			base = counter_base(row, key);
			for (int j = 0; j < 16; j++)
				if (sketch[row][base+j] < lowest[j]) lowest[j] = sketch[row][base+j];
		end
		total = 0;
		zeros = 0;
		for (int j = 0; j < 16; j++) begin
			r = lowest[j] > 29 ? 29 : lowest[j];
			total += 64'd1 << (29 - r);
			if (lowest[j] == 0) zeros++;
		end
		est = ((64'd44106 * 256) << 29) / total;
		if (est <= 64'd2621440) begin
			ans = 64'(kjss_pkg::small_range(5'(zeros)));
		end else begin
			ans = est >> 16;
			if (ans > 64'hFFFFFFFF) ans = 64'hFFFFFFFF;
		end
		return ans[31:0];
	endfunction

	function automatic void record_element(input logic [31:0] key, input logic [31:0] ele);
		logic [31:0] h;
		logic [4:0]  rank;
		int idx;
		h = mix_word(ele, elem_seed);
		rank = 5'd29;
		for (int b = 27; b >= 0; b--)
			if (h[b]) begin
				rank = 5'(28 - b);
				break;
			end
		for (int row = 0; row < ROWS; row++) begin
			idx = counter_base(row, key) + int'(h[31:28]);
			if (sketch[row][idx] < rank) sketch[row][idx] = rank;
		end
	endfunction

	assign pending = estimate_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int row = 0; row < 3; row++)
				for (int i = 0; i < COLS*16; i++) sketch[row][i] = '0;
			key_seed[0] = 32'd0;
			key_seed[1] = 32'd1;
			key_seed[2] = 32'd2;
			elem_seed = 32'd3;
			estimate_q.delete();
			fail_count = 0;
			estimates_seen = 0;
		end else begin
			if (done) begin
				estimates_seen++;
				if (estimate_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected estimate %0d", $time, spread_estimate);
				end else begin
					logic [31:0] want;
					want = estimate_q.pop_front();
					if (want !== spread_estimate) begin
						fail_count++;
						$display("%0t: estimate expected %0d actual %0d",
							$time, want, spread_estimate);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					kjss_pkg::REG_ROW0_SEED: key_seed[0] = pwdata;
					kjss_pkg::REG_ROW1_SEED: key_seed[1] = pwdata;
					kjss_pkg::REG_ROW2_SEED: key_seed[2] = pwdata;
					kjss_pkg::REG_ELEM_SEED: elem_seed = pwdata;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (opcode) estimate_q.push_back(spread_of(flow_key));
				else record_element(flow_key, element);
			end
		end
	end
endmodule

// ----- bench/tb_kjoin_spread_sketch_unit.sv -----
// ----------------------------------------------------------------------------
// tb_kjoin_spread_sketch_unit
// Drives seeds and record/query commands into the spread sketch with random
// gaps; the checker beside the block predicts and compares every estimate.
// ----------------------------------------------------------------------------
module tb_kjoin_spread_sketch_unit;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic        opcode = 1'b0;
	logic [31:0] flow_key = '0;
	logic [31:0] element = '0;
	logic        done;
	logic [31:0] spread_estimate;
	int          fail_count;
	int          pending;
	int          estimates_seen;
	int          idle_cycles = 0;
	int          items_sent = 0;
	logic [31:0] flows [8];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	kjoin_spread_sketch_unit dut (.*);

	kjss_checker chk (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_seed(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one transaction, held until the block takes it
	task automatic issue(input logic op, input logic [31:0] key, input logic [31:0] ele);
		@(posedge clk);
		start <= 1'b1;
		opcode <= op;
		flow_key <= key;
		element <= ele;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		items_sent++;
	endtask

	task automatic gap();
		int n;
		n = $urandom_range(3) == 0 ? 0 : $urandom_range(10);
		repeat (n) @(posedge clk);
	endtask

	// drain results, then cover the update latency before touching seeds
	task automatic settle();
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		logic [31:0] key;
		for (int i = 0; i < count; i++) begin
			key = $urandom_range(4) == 0 ? $urandom() : flows[$urandom_range(7)];
			if ($urandom_range(3) == 0) issue(1'b1, key, $urandom());
			else issue(1'b0, key, $urandom());
			if (i > count / 4 && i < count / 2) begin
				// back to back stretch
			end else begin
				gap();
			end
			if (i == count / 2) settle();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 8; i++) flows[i] = $urandom();
		issue(1'b1, 32'h0, 32'h0);
		issue(1'b0, 32'h0, 32'h0);
		issue(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		issue(1'b1, 32'h0, 32'hFFFFFFFF);
		issue(1'b1, 32'hFFFFFFFF, 32'h0);
		for (int i = 0; i < 12; i++) issue(1'b0, flows[0], 32'(i));
		issue(1'b1, flows[0], 32'h0);
		issue(1'b1, flows[1], $urandom());
		settle();
		write_seed(kjss_pkg::REG_ROW0_SEED, 32'hFFFFFFFF);
		write_seed(kjss_pkg::REG_ROW1_SEED, 32'h0);
		write_seed(kjss_pkg::REG_ROW2_SEED, 32'h80000000);
		write_seed(kjss_pkg::REG_ELEM_SEED, 32'hFFFFFFFF);
		random_phase(400);
		settle();
		write_seed(kjss_pkg::REG_ROW0_SEED, $urandom());
		write_seed(kjss_pkg::REG_ROW1_SEED, $urandom());
		write_seed(kjss_pkg::REG_ROW2_SEED, $urandom());
		write_seed(kjss_pkg::REG_ELEM_SEED, 32'h0);
		random_phase(400);
		settle();
		write_seed(kjss_pkg::REG_ROW0_SEED, 32'h0);
		write_seed(kjss_pkg::REG_ROW1_SEED, 32'h1);
		write_seed(kjss_pkg::REG_ROW2_SEED, 32'h2);
		write_seed(kjss_pkg::REG_ELEM_SEED, $urandom());
		random_phase(400);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d commands over four seed settings, checked %0d estimates.",
			items_sent, estimates_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
